@@ design/rdc_pkg.sv @@
// Package for the radix digit-coded converter.
// Holds digit widths, radix limits, operation codes and the control structs
// shared by the sequencer, the digit register and the accumulator.
`default_nettype none

package rdc_pkg;

  localparam int unsigned DigitW = 4;
  localparam int unsigned BaseW  = 4;

  localparam logic [BaseW-1:0] BASE_MIN  = 4'd2;
  localparam logic [BaseW-1:0] BASE_MAX  = 4'd10;
  localparam logic [BaseW-1:0] DEC_RADIX = 4'd10;

  localparam logic OP_TO_CODED   = 1'b0;
  localparam logic OP_FROM_CODED = 1'b1;

  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
  } dig_ctl_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic check;
  } mac_ctl_t;

  function automatic logic [BaseW-1:0] clamp_base(input logic [BaseW-1:0] b);
    logic [BaseW-1:0] r;
    r = b;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/rdc_digit_reg.sv @@
// Radix digit register: shifts a binary value in one bit per beat, MSB first,
// doubling a row of radix-r digit cells with a single carry chain per cycle.
// Shifts the digits out MSB first afterwards. Depends on rdc_pkg.
`default_nettype none

module rdc_digit_reg #(
  parameter int unsigned NUMBER_WIDTH = 64
) (
  input  logic                              clk_i,
  input  rdc_pkg::dig_ctl_t                 ctl_i,
  input  logic [rdc_pkg::BaseW-1:0]         radix_i,
  input  logic                              bit_i,
  output logic [rdc_pkg::DigitW-1:0]        top_o
);
  import rdc_pkg::*;

  logic [DigitW-1:0]     dig_q [NUMBER_WIDTH];
  logic [DigitW-1:0]     dig_d [NUMBER_WIDTH];
  logic [NUMBER_WIDTH-1:0] gen;
  logic [NUMBER_WIDTH-1:0] prop;
  logic [NUMBER_WIDTH-1:0] sum;
  logic [NUMBER_WIDTH-1:0] cin;

  always_comb begin
    for (int i = 0; i < NUMBER_WIDTH; i++) begin
      gen[i]  = {dig_q[i], 1'b0} >= {1'b0, radix_i};
      prop[i] = {dig_q[i], 1'b1} == {1'b0, radix_i};
    end
  end

  assign sum = (gen | prop) + gen + {{(NUMBER_WIDTH-1){1'b0}}, bit_i};
  assign cin = sum ^ (gen | prop) ^ gen;

  always_comb begin
    logic [DigitW:0] v;
    v = '0;
    for (int i = 0; i < NUMBER_WIDTH; i++) begin
      dig_d[i] = dig_q[i];
      if (ctl_i.clear) begin
        dig_d[i] = '0;
      end else if (ctl_i.conv) begin
        v = {dig_q[i], cin[i]};
        if (v >= {1'b0, radix_i}) begin
          v = v - {1'b0, radix_i};
        end
        dig_d[i] = v[DigitW-1:0];
      end else if (ctl_i.shift) begin
        dig_d[i] = (i == 0) ? '0 : dig_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUMBER_WIDTH; i++) begin
      dig_q[i] <= dig_d[i];
    end
  end

  assign top_o = dig_q[NUMBER_WIDTH-1];

endmodule

`default_nettype wire

@@ design/rdc_mac.sv @@
// Horner accumulator: acc = acc * mul + digit, one digit per cycle,
// with sticky overflow and digit range flags. Depends on rdc_pkg.
`default_nettype none

module rdc_mac #(
  parameter int unsigned NUMBER_WIDTH = 64
) (
  input  logic                          clk_i,
  input  rdc_pkg::mac_ctl_t             ctl_i,
  input  logic [rdc_pkg::BaseW-1:0]     mul_i,
  input  logic [rdc_pkg::DigitW-1:0]    digit_i,
  output logic [NUMBER_WIDTH-1:0]       acc_o,
  output logic                          ovf_o,
  output logic                          derr_o
);
  import rdc_pkg::*;

  localparam int unsigned ProdW = NUMBER_WIDTH + BaseW + 1;

  logic [NUMBER_WIDTH-1:0] acc_q, acc_d;
  logic                    ovf_q, ovf_d;
  logic                    derr_q, derr_d;
  logic [ProdW-1:0]        full;

  assign full = ProdW'(acc_q) * ProdW'(mul_i) + ProdW'(digit_i);

  always_comb begin
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    derr_d = derr_q;
    if (ctl_i.clear) begin
      acc_d  = '0;
      ovf_d  = 1'b0;
      derr_d = 1'b0;
    end else if (ctl_i.step) begin
      acc_d  = full[NUMBER_WIDTH-1:0];
      ovf_d  = ovf_q | (|full[ProdW-1:NUMBER_WIDTH]);
      derr_d = derr_q | (ctl_i.check & ({1'b0, digit_i} >= {1'b0, mul_i}));
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    ovf_q  <= ovf_d;
    derr_q <= derr_d;
  end

  assign acc_o  = acc_q;
  assign ovf_o  = ovf_q;
  assign derr_o = derr_q;

endmodule

`default_nettype wire

@@ design/radix_digit_coded_converter.sv @@
// Top level of the radix digit-coded converter: sequencer, output register,
// and instances of rdc_digit_reg and rdc_mac. Depends on rdc_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries op_i, base_i, number_i.
//   Output channel (out_valid_o / out_stall_i) carries result_o,
//   digit_error_o and overflow_o, one beat per input beat.
//   op_i = 0 writes the base-b digits of number_i as a decimal numeral;
//   op_i = 1 reads the decimal digits of number_i as base-b digits.
//   Base values below 2 act as 2, above 10 act as 10.
//   Each item is worked in order: NUMBER_WIDTH operand bits are shifted
//   into the radix digit row, one bit per cycle through its carry chain,
//   then NUMBER_WIDTH Horner steps run through the one multiply-add unit,
//   and the output register is loaded. in_stall_o stays high while an
//   item is in work, so a new item is taken only once the last one has
//   left the sequencer. A new item is taken while a finished result still
//   waits on the output register.
//   If the receiver stalls, the result holds and the next finished item
//   waits in the sequencer until the output register frees up.
//   Reset clears the sequencer and drops any pending result.
`default_nettype none

module radix_digit_coded_converter #(
  parameter int unsigned NUMBER_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [3:0]  base_i,
  input  logic [63:0] number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_o,
  output logic        digit_error_o,
  output logic        overflow_o
);
  import rdc_pkg::*;

  localparam int unsigned CntW = $clog2(NUMBER_WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(NUMBER_WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_ACC,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [CntW-1:0]         cnt_q;
  logic [NUMBER_WIDTH-1:0] n_q;
  logic [BaseW-1:0]        radix_q;
  logic [BaseW-1:0]        mul_q;
  logic                    op_q;
  logic                    out_valid_q;
  logic [63:0]             result_q;
  logic                    derr_q;
  logic                    ovf_q;

  logic                    in_acc;
  logic                    out_free;
  logic [BaseW-1:0]        base_c;
  dig_ctl_t                dig_ctl;
  mac_ctl_t                mac_ctl;
  logic [DigitW-1:0]       top_dig;
  logic [NUMBER_WIDTH-1:0] acc;
  logic                    mac_ovf;
  logic                    mac_derr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign base_c     = clamp_base(base_i);

  always_comb begin
    dig_ctl       = '0;
    mac_ctl       = '0;
    dig_ctl.clear = in_acc;
    dig_ctl.conv  = (state_q == ST_CONV);
    dig_ctl.shift = (state_q == ST_ACC);
    mac_ctl.clear = in_acc;
    mac_ctl.step  = (state_q == ST_ACC);
    mac_ctl.check = (op_q == OP_FROM_CODED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_CONV;
            cnt_q   <= CntLast;
          end
        end
        ST_CONV: begin
          if (cnt_q == '0) begin
            state_q <= ST_ACC;
            cnt_q   <= CntLast;
          end else begin
            cnt_q <= cnt_q - CntW'(1);
          end
        end
        ST_ACC: begin
          if (cnt_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q - CntW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      n_q  <= number_i[NUMBER_WIDTH-1:0];
      op_q <= op_i;
      if (op_i == OP_TO_CODED) begin
        radix_q <= base_c;
        mul_q   <= DEC_RADIX;
      end else begin
        radix_q <= DEC_RADIX;
        mul_q   <= base_c;
      end
    end else if (state_q == ST_CONV) begin
      n_q <= {n_q[NUMBER_WIDTH-2:0], 1'b0};
    end
    if (state_q == ST_DONE && out_free) begin
      result_q <= 64'(acc);
      derr_q   <= mac_derr;
      ovf_q    <= mac_ovf;
    end
  end

  rdc_digit_reg #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_digits (
    .clk_i  (clk_i),
    .ctl_i  (dig_ctl),
    .radix_i(radix_q),
    .bit_i  (n_q[NUMBER_WIDTH-1]),
    .top_o  (top_dig)
  );

  rdc_mac #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .mul_i  (mul_q),
    .digit_i(top_dig),
    .acc_o  (acc),
    .ovf_o  (mac_ovf),
    .derr_o (mac_derr)
  );

  assign out_valid_o   = out_valid_q;
  assign result_o      = result_q;
  assign digit_error_o = derr_q;
  assign overflow_o    = ovf_q;

endmodule

`default_nettype wire

@@ design/rdc_checker.sv @@
// Port checker for the radix digit-coded converter, with its bind statement.
// Watches only the top-level ports. Depends on radix_digit_coded_converter.
`default_nettype none

module rdc_checker #(
  parameter int unsigned NUMBER_WIDTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] result_o
);

  logic in_beat;
  assign in_beat = in_valid_i & ~in_stall_o;

  a_busy_after_beat: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_beat |=> in_stall_o
  ) else $error("input side not busy after an input beat");

  a_result_after_work: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_o) |-> $past(in_stall_o)
  ) else $error("result appeared without an item in work");

  a_result_width: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> ((result_o >> NUMBER_WIDTH) == 64'd0)
  ) else $error("result exceeds the number width");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o)
  ) else $error("stalled result beat changed");

endmodule

bind radix_digit_coded_converter rdc_checker #(
  .NUMBER_WIDTH(NUMBER_WIDTH)
) u_rdc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .result_o   (result_o)
);

`default_nettype wire
